// ===== rtl/jlkv_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jlkv_pkg
// Shared types and constants for the JSON line key/value extractor.
// ---------------------------------------------------------------------------
package jlkv_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_KEY_LEN  = 3'd0;
	localparam logic [2:0] REG_KEY_LO   = 3'd1;
	localparam logic [2:0] REG_KEY_HI   = 3'd2;
	localparam logic [2:0] REG_KIND     = 3'd3;
	localparam logic [2:0] REG_ELEM_IDX = 3'd4;
	localparam logic [2:0] REG_CAPACITY = 3'd5;

	// value kinds
	localparam logic [1:0] KIND_STRING = 2'd0;
	localparam logic [1:0] KIND_BOOL   = 2'd1;
	localparam logic [1:0] KIND_DIGITS = 2'd2;
	localparam logic [1:0] KIND_ARRAY  = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// "true" and "false" spelled out, first letter lowest
	localparam logic [39:0] LIT_TRUE  = 40'h0065757274;
	localparam logic [39:0] LIT_FALSE = 40'h65736c6166;

	// byte classification produced by the front end
	typedef struct packed {
		logic       eol;
		logic [7:0] ch;
		logic       quote;
		logic       bslash;
		logic       colon;
		logic       lbrack;
		logic       blank;
		logic       comma;
		logic       digit;
	} cls_word_t;

	// one result word
	typedef struct packed {
		logic       kind;
		logic [7:0] vbyte;
		logic       ok;
		logic       bval;
		logic [7:0] len;
		logic       last;
	} res_word_t;

endpackage
`default_nettype wire

// ===== rtl/jlkv_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jlkv_front
// Accepts text words, classifies the byte and queues it for the parser.
// ---------------------------------------------------------------------------
module jlkv_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          in_byte,
	input  wire logic                in_eol,
	output logic                     q_valid,
	input  wire logic                q_ready,
	output jlkv_pkg::cls_word_t      q_word
);

	jlkv_pkg::cls_word_t cls;
	jlkv_pkg::cls_word_t mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push, pop;

	// byte classification
	always_comb begin
		cls.eol    = in_eol;
		cls.ch     = in_byte;
		cls.quote  = in_byte == jlkv_pkg::CH_QUOTE;
		cls.bslash = in_byte == jlkv_pkg::CH_BSLASH;
		cls.colon  = in_byte == jlkv_pkg::CH_COLON;
		cls.lbrack = in_byte == jlkv_pkg::CH_LBRACK;
		cls.blank  = in_byte == jlkv_pkg::CH_SPACE || in_byte == jlkv_pkg::CH_TAB;
		cls.comma  = in_byte == jlkv_pkg::CH_COMMA;
		cls.digit  = in_byte >= 8'h30 && in_byte <= 8'h39;
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign q_word   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jlkv_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jlkv_back
// Parser state machine: key match, value extraction and result output.
// ---------------------------------------------------------------------------
module jlkv_back #(
	parameter int KEY_MAX = 16,
	parameter int OUT_MAX = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_ready,
	input  wire jlkv_pkg::cls_word_t q_word,
	input  wire logic [4:0]          key_len,
	input  wire logic [127:0]        key_bytes,
	input  wire logic [1:0]          vkind,
	input  wire logic [15:0]         elem_idx,
	input  wire logic [8:0]          capacity,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output jlkv_pkg::res_word_t      res_word
);

	typedef enum logic [3:0] {
		PH_SEARCH, PH_AFTER_KEY, PH_AFTER_COLON, PH_STRING, PH_BOOL,
		PH_DIGITS, PH_WAIT_BRACKET, PH_BETWEEN, PH_OK, PH_FAIL
	} phase_t;

	localparam logic [4:0] KMAX = 5'(KEY_MAX);
	localparam logic [8:0] OMAX = 9'(OUT_MAX);

	phase_t      phase_q, ph_n;
	logic [4:0]  mpos_q, mpos_n;
	logic [8:0]  len_q, len_n;
	logic [15:0] seen_q, seen_n;
	logic        esc_q, esc_n;
	logic [2:0]  lprog_q, lprog_n;
	logic        lfalse_q, lfalse_n;
	logic        emit;
	jlkv_pkg::res_word_t rw;

	logic [4:0]  klen;
	logic [8:0]  cap;
	logic [7:0]  c;
	logic [7:0]  kch;
	logic [3:0]  kidx;
	logic        chosen, ok_st, take, dig_ok;
	logic [2:0]  total, p;
	logic [7:0]  want;
	logic [39:0] lit;

	assign klen = (key_len > KMAX) ? KMAX : key_len;
	assign cap  = (capacity > OMAX) ? OMAX : capacity;
	assign c    = q_word.ch;
	assign kidx = 4'(mpos_q - 5'd1);
	assign kch  = key_bytes[{kidx, 3'b000} +: 8];
	assign chosen = vkind != jlkv_pkg::KIND_ARRAY || seen_q == elem_idx;
	assign dig_ok = q_word.digit && ({1'b0, len_q} + 10'd1 < {1'b0, cap});
	assign total  = lfalse_q ? 3'd5 : 3'd4;
	assign p      = (lprog_q < total) ? lprog_q : total - 3'd1;
	assign lit    = lfalse_q ? jlkv_pkg::LIT_FALSE : jlkv_pkg::LIT_TRUE;
	assign want   = lit[{p, 3'b000} +: 8];
	assign ok_st  = phase_q == PH_OK || (phase_q == PH_DIGITS && len_q != 9'd0);

	// output register frees when taken
	assign q_ready = !res_valid || res_ready;
	assign take    = q_valid && q_ready;

	// next-state logic for one byte
	always_comb begin
		ph_n = phase_q; mpos_n = mpos_q; len_n = len_q; seen_n = seen_q;
		esc_n = esc_q; lprog_n = lprog_q; lfalse_n = lfalse_q;
		emit = 1'b0;
		rw = '0;
		rw.vbyte = c;
		if (q_word.eol) begin
			emit = 1'b1;
			rw.kind = 1'b1; rw.vbyte = 8'd0; rw.last = 1'b1; rw.ok = ok_st;
			rw.bval = ok_st && vkind == jlkv_pkg::KIND_BOOL && !lfalse_q;
			rw.len = (ok_st && vkind != jlkv_pkg::KIND_BOOL) ? len_q[7:0] : 8'd0;
			ph_n = PH_SEARCH; mpos_n = '0; len_n = '0; seen_n = '0;
			esc_n = 1'b0; lprog_n = '0; lfalse_n = 1'b0;
		end else begin
			case (phase_q)
				PH_SEARCH: begin
					if (mpos_q == 5'd0)
						mpos_n = {4'd0, q_word.quote};
					else if (mpos_q <= klen)
						mpos_n = (c == kch) ? mpos_q + 5'd1 : {4'd0, q_word.quote};
					else if (q_word.quote)
						ph_n = (vkind == jlkv_pkg::KIND_ARRAY) ? PH_WAIT_BRACKET : PH_AFTER_KEY;
					else
						mpos_n = '0;
				end
				PH_AFTER_KEY: begin
					if (q_word.colon) ph_n = PH_AFTER_COLON;
					else if (!q_word.blank) ph_n = PH_FAIL;
				end
				PH_AFTER_COLON: begin
					if (!q_word.blank) begin
						case (vkind)
							jlkv_pkg::KIND_STRING: ph_n = q_word.quote ? PH_STRING : PH_FAIL;
							jlkv_pkg::KIND_BOOL: begin
								if (c == 8'h74 || c == 8'h66) begin
									lfalse_n = c == 8'h66; lprog_n = 3'd1; ph_n = PH_BOOL;
								end else ph_n = PH_FAIL;
							end
							jlkv_pkg::KIND_DIGITS: begin
								if (dig_ok) begin
									ph_n = PH_DIGITS; emit = 1'b1; len_n = len_q + 9'd1;
								end else ph_n = (len_q != 9'd0) ? PH_OK : PH_FAIL;
							end
							default: ph_n = PH_FAIL;
						endcase
					end
				end
				PH_BOOL: begin
					if (c == want) begin
						lprog_n = p + 3'd1;
						if (p + 3'd1 == total) ph_n = PH_OK;
					end else ph_n = PH_FAIL;
				end
				PH_DIGITS: begin
					if (dig_ok) begin
						emit = 1'b1; len_n = len_q + 9'd1;
					end else ph_n = (len_q != 9'd0) ? PH_OK : PH_FAIL;
				end
				PH_WAIT_BRACKET: if (q_word.lbrack) ph_n = PH_BETWEEN;
				PH_BETWEEN: begin
					if (!(q_word.blank || q_word.comma)) begin
						if (q_word.quote) begin
							len_n = '0; esc_n = 1'b0; ph_n = PH_STRING;
						end else ph_n = PH_FAIL;
					end
				end
				PH_STRING: begin
					if (esc_q) begin
						esc_n = 1'b0; emit = chosen; len_n = len_q + 9'd1;
					end else if (q_word.quote) begin
						if (len_q >= cap) ph_n = PH_FAIL;
						else if (chosen) ph_n = PH_OK;
						else begin
							seen_n = seen_q + 16'd1; len_n = '0; ph_n = PH_BETWEEN;
						end
					end else if ({1'b0, len_q} + 10'd1 >= {1'b0, cap}) begin
						ph_n = PH_FAIL;
					end else begin
						esc_n = q_word.bslash; emit = chosen; len_n = len_q + 9'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH; mpos_q <= '0; len_q <= '0; seen_q <= '0;
			esc_q <= 1'b0; lprog_q <= '0; lfalse_q <= 1'b0;
			res_valid <= 1'b0; res_word <= '0;
		end else begin
			res_valid <= (take && emit) || (res_valid && !res_ready);
			if (take) begin
				phase_q <= ph_n; mpos_q <= mpos_n; len_q <= len_n; seen_q <= seen_n;
				esc_q <= esc_n; lprog_q <= lprog_n; lfalse_q <= lfalse_n;
				if (emit)
					res_word <= rw;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/json_line_key_value_extractor.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// json_line_key_value_extractor
// Extracts the value of a configured key from one JSON line per run.
// ---------------------------------------------------------------------------
// One text byte is taken per cycle, back to back; each byte yields at most
// one word, so the rate is one byte per cycle while the result side keeps up.
// A two-word queue sits between the classifying front end and the parser;
// the parser takes the next byte in the same cycle its waiting word leaves,
// and stalls only while that word is held back. A byte is written into the queue
// first, and its word is then registered in the parser's output register.
// Value bytes leave tentatively (tuser 0); end of line gives one status word
// (tuser 1, tlast 1) whose success bit says whether to keep them.
module json_line_key_value_extractor #(
	parameter int KEY_MAX = 16,
	parameter int OUT_MAX = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // text_byte
	input  wire logic        s_axis_tlast,   // end_of_line
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // value_byte, success, bool_result, value_length
	output logic             m_axis_tuser,   // result_kind
	output logic             m_axis_tlast,   // last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [4:0]   key_len_q;
	logic [127:0] key_q;
	logic [1:0]   kind_q;
	logic [15:0]  idx_q;
	logic [8:0]   cap_q;
	logic         q_valid, q_ready;
	jlkv_pkg::cls_word_t q_word;
	jlkv_pkg::res_word_t res_word;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0; key_q <= '0; kind_q <= '0; idx_q <= '0; cap_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				jlkv_pkg::REG_KEY_LEN:  key_len_q     <= cfg_data[4:0];
				jlkv_pkg::REG_KEY_LO:   key_q[63:0]   <= cfg_data;
				jlkv_pkg::REG_KEY_HI:   key_q[127:64] <= cfg_data;
				jlkv_pkg::REG_KIND:     kind_q        <= cfg_data[1:0];
				jlkv_pkg::REG_ELEM_IDX: idx_q         <= cfg_data[15:0];
				jlkv_pkg::REG_CAPACITY: cap_q         <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	jlkv_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_eol(s_axis_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
	);

	jlkv_back #(.KEY_MAX(KEY_MAX), .OUT_MAX(OUT_MAX)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
		.key_len(key_len_q), .key_bytes(key_q), .vkind(kind_q),
		.elem_idx(idx_q), .capacity(cap_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_word(res_word)
	);

	// result word packing
	assign m_axis_tuser = res_word.kind;
	assign m_axis_tlast = res_word.last;
	assign m_axis_tdata = {6'b000000, res_word.len, res_word.bval, res_word.ok,
		res_word.vbyte};

endmodule
`default_nettype wire

// ===== verif/jlkv_checker.sv =====
// ---------------------------------------------------------------------------
// jlkv_checker
// Watches the text, result and register channels of the JSON line key/value
// extractor, predicts every result word from the accepted text bytes and
// compares each result word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module jlkv_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,
	input  wire logic        m_axis_tuser,
	input  wire logic        m_axis_tlast,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output int               pending,
	output int               errors,
	output int               statuses_ok
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		PH_SEARCH, PH_AFTER_KEY, PH_AFTER_COLON, PH_STRING, PH_BOOL,
		PH_DIGITS, PH_WAIT_BRACKET, PH_BETWEEN, PH_OK, PH_FAIL
	} parse_phase_t;

	// register copy
	logic [4:0]  key_len;
	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [1:0]  kind;
	logic [15:0] elem_idx;
	logic [8:0]  capacity;

	// parser state copy
	logic [4:0]   match_pos;
	parse_phase_t ph;
	logic [8:0]   len_so_far;
	logic [15:0]  elems_seen;
	logic         esc_pending;
	logic [2:0]   lit_prog;
	logic         lit_false;

	jlkv_pkg::res_word_t expected_words[$];

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic clear_line();
		match_pos = '0;
		ph = PH_SEARCH;
		len_so_far = '0;
		elems_seen = '0;
		esc_pending = 1'b0;
		lit_prog = '0;
		lit_false = 1'b0;
	endtask

	task automatic push_byte(input logic [7:0] c);
		jlkv_pkg::res_word_t w;
		w = '0;
		w.vbyte = c;
		expected_words.push_back(w);
	endtask

	function automatic logic [7:0] key_char(input int i);
		if (i < 8)
			return key_lo[8*i +: 8];
		return key_hi[8*(i-8) +: 8];
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == jlkv_pkg::CH_SPACE || c == jlkv_pkg::CH_TAB;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// one accepted text word through the parser copy
	task automatic predict_word(input logic [7:0] c, input logic eol);
		int unsigned klen;
		int unsigned cap;
		int unsigned total;
		int unsigned p;
		logic [7:0]  want;
		logic        ok;
		logic        chosen;
		jlkv_pkg::res_word_t w;
		klen = key_len > 16 ? 16 : key_len;
		cap = capacity > 256 ? 256 : capacity;
		if (eol) begin
			ok = ph == PH_OK || (ph == PH_DIGITS && len_so_far > 0);
			w = '0;
			w.kind = 1'b1;
			w.ok = ok;
			w.bval = ok && kind == jlkv_pkg::KIND_BOOL && !lit_false;
			w.len = (ok && kind != jlkv_pkg::KIND_BOOL) ? len_so_far[7:0] : 8'd0;
			w.last = 1'b1;
			expected_words.push_back(w);
			clear_line();
			return;
		end
		case (ph)
			PH_SEARCH: begin
				if (match_pos == 0)
					match_pos = (c == jlkv_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
				else if (match_pos <= klen) begin
					if (c == key_char(match_pos - 1))
						match_pos++;
					else
						match_pos = (c == jlkv_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
				end else if (c == jlkv_pkg::CH_QUOTE)
					ph = (kind == jlkv_pkg::KIND_ARRAY) ? PH_WAIT_BRACKET : PH_AFTER_KEY;
				else
					match_pos = '0;
			end
			PH_AFTER_KEY: begin
				if (c == jlkv_pkg::CH_COLON)
					ph = PH_AFTER_COLON;
				else if (!is_blank(c))
					ph = PH_FAIL;
			end
			PH_AFTER_COLON: begin
				if (!is_blank(c)) begin
					case (kind)
						jlkv_pkg::KIND_STRING:
							ph = (c == jlkv_pkg::CH_QUOTE) ? PH_STRING : PH_FAIL;
						jlkv_pkg::KIND_BOOL: begin
							if (c == "t" || c == "f") begin
								lit_false = c == "f";
								lit_prog = 3'd1;
								ph = PH_BOOL;
							end else
								ph = PH_FAIL;
						end
						jlkv_pkg::KIND_DIGITS: begin
							ph = PH_DIGITS;
							if (is_digit(c) && len_so_far + 1 < cap) begin
								push_byte(c);
								len_so_far++;
							end else
								ph = len_so_far > 0 ? PH_OK : PH_FAIL;
						end
						default: ph = PH_FAIL;
					endcase
				end
			end
			PH_BOOL: begin
				total = lit_false ? 5 : 4;
				p = lit_prog < total ? lit_prog : total - 1;
				want = lit_false ? jlkv_pkg::LIT_FALSE[8*p +: 8] : jlkv_pkg::LIT_TRUE[8*p +: 8];
				if (c == want) begin
					lit_prog = 3'(p + 1);
					if (lit_prog == total)
						ph = PH_OK;
				end else
					ph = PH_FAIL;
			end
			PH_DIGITS: begin
				if (is_digit(c) && len_so_far + 1 < cap) begin
					push_byte(c);
					len_so_far++;
				end else
					ph = len_so_far > 0 ? PH_OK : PH_FAIL;
			end
			PH_WAIT_BRACKET: begin
				if (c == jlkv_pkg::CH_LBRACK)
					ph = PH_BETWEEN;
			end
			PH_BETWEEN: begin
				if (!(is_blank(c) || c == jlkv_pkg::CH_COMMA)) begin
					if (c == jlkv_pkg::CH_QUOTE) begin
						len_so_far = '0;
						esc_pending = 1'b0;
						ph = PH_STRING;
					end else
						ph = PH_FAIL;
				end
			end
			PH_STRING: begin
				chosen = kind != jlkv_pkg::KIND_ARRAY || elems_seen == elem_idx;
				if (esc_pending) begin
					esc_pending = 1'b0;
					if (chosen)
						push_byte(c);
					len_so_far++;
				end else if (c == jlkv_pkg::CH_QUOTE) begin
					if (len_so_far >= cap)
						ph = PH_FAIL;
					else if (chosen)
						ph = PH_OK;
					else begin
						elems_seen++;
						len_so_far = '0;
						ph = PH_BETWEEN;
					end
				end else if (len_so_far + 1 >= cap)
					ph = PH_FAIL;
				else begin
					if (c == jlkv_pkg::CH_BSLASH)
						esc_pending = 1'b1;
					if (chosen)
						push_byte(c);
					len_so_far++;
				end
			end
			default: ;
		endcase
	endtask

	// register copy, text prediction and result comparison
	always @(posedge clk or negedge arst_n) begin
		jlkv_pkg::res_word_t w;
		if (!arst_n) begin
			key_len = '0;
			key_lo = '0;
			key_hi = '0;
			kind = jlkv_pkg::KIND_STRING;
			elem_idx = '0;
			capacity = 9'd256;
			clear_line();
			expected_words.delete();
			pending = 0;
			errors = 0;
			statuses_ok = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0)
					report("unexpected word, tuser", m_axis_tuser, 0);
				else begin
					w = expected_words.pop_front();
					if (m_axis_tuser !== w.kind)
						report("result_kind", m_axis_tuser, w.kind);
					if (m_axis_tdata[7:0] !== w.vbyte)
						report("value_byte", m_axis_tdata[7:0], w.vbyte);
					if (m_axis_tdata[8] !== w.ok)
						report("success", m_axis_tdata[8], w.ok);
					if (m_axis_tdata[9] !== w.bval)
						report("bool_result", m_axis_tdata[9], w.bval);
					if (m_axis_tdata[17:10] !== w.len)
						report("value_length", m_axis_tdata[17:10], w.len);
					if (m_axis_tlast !== w.last)
						report("last", m_axis_tlast, w.last);
					if (m_axis_tdata[23:18] !== 6'd0)
						report("tdata padding", m_axis_tdata[23:18], 0);
					if (w.kind && w.ok)
						statuses_ok++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_word(s_axis_tdata, s_axis_tlast);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					jlkv_pkg::REG_KEY_LEN:  key_len = cfg_data[4:0];
					jlkv_pkg::REG_KEY_LO:   key_lo = cfg_data;
					jlkv_pkg::REG_KEY_HI:   key_hi = cfg_data;
					jlkv_pkg::REG_KIND:     kind = cfg_data[1:0];
					jlkv_pkg::REG_ELEM_IDX: elem_idx = cfg_data[15:0];
					jlkv_pkg::REG_CAPACITY: capacity = cfg_data[8:0];
					default: ;
				endcase
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== verif/json_line_key_value_extractor_tb.sv =====
// ---------------------------------------------------------------------------
// json_line_key_value_extractor_tb
// Drives JSON lines into the extractor under a series of key, kind and
// capacity settings, with random gaps and back-pressure; the checker beside
// the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module json_line_key_value_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEM_TARGET = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int pending;
	int errors;
	int statuses_ok;
	int bytes_sent;
	int lines_sent;
	int settings_run;
	int idle_cycles;
	bit sink_steady;
	int sink_wait;

	logic [7:0] key_chars[16];
	int         key_n;
	logic [1:0] cur_kind;
	logic [7:0] line_bytes[$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	json_line_key_value_extractor i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	jlkv_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors), .statuses_ok(statuses_ok)
	);

	// result sink: random stall after some words, steady stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_wait <= 0;
			sink_steady <= 1'b0;
		end else if (m_axis_tready && m_axis_tvalid) begin
			if ($urandom_range(0, 49) == 0)
				sink_steady <= !sink_steady;
			if (sink_steady || $urandom_range(0, 6) == 0) begin
				sink_wait <= 0;
			end else begin
				sink_wait <= $urandom_range(1, 6);
				m_axis_tready <= 1'b0;
			end
		end else if (sink_wait > 1) begin
			sink_wait <= sink_wait - 1;
		end else begin
			sink_wait <= 0;
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d words outstanding", pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_text(input logic [7:0] c, input logic eol);
		int gap;
		gap = sink_steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= eol;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_line();
		foreach (line_bytes[i])
			send_text(line_bytes[i], 1'b0);
		send_text(8'($urandom_range(0, 255)), 1'b1);
		lines_sent++;
		line_bytes.delete();
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	task automatic put_blanks();
		repeat ($urandom_range(0, 2))
			line_bytes.push_back($urandom_range(0, 1) ? jlkv_pkg::CH_SPACE : jlkv_pkg::CH_TAB);
	endtask

	task automatic put_key();
		line_bytes.push_back(jlkv_pkg::CH_QUOTE);
		for (int i = 0; i < key_n; i++)
			line_bytes.push_back(key_chars[i]);
		line_bytes.push_back(jlkv_pkg::CH_QUOTE);
	endtask

	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return jlkv_pkg::CH_SPACE;
		if (r < 4)
			return 8'($urandom_range("0", "9"));
		return 8'($urandom_range("a", "z"));
	endfunction

	// quoted string body with escape pairs; sometimes left open
	task automatic put_string(input int maxlen);
		int n;
		line_bytes.push_back(jlkv_pkg::CH_QUOTE);
		n = $urandom_range(0, maxlen);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				line_bytes.push_back(jlkv_pkg::CH_BSLASH);
				line_bytes.push_back($urandom_range(0, 1) ? jlkv_pkg::CH_QUOTE : "n");
			end else
				line_bytes.push_back(text_char());
		end
		if ($urandom_range(0, 15) != 0)
			line_bytes.push_back(jlkv_pkg::CH_QUOTE);
	endtask

	task automatic put_value(input logic [1:0] k);
		int n;
		case (k)
			jlkv_pkg::KIND_STRING: put_string($urandom_range(0, 9) == 0 ? 24 : 8);
			jlkv_pkg::KIND_BOOL: begin
				case ($urandom_range(0, 5))
					0: put_str("tru");
					1: put_str("fals");
					2: put_str("trUe");
					3, 4: put_str("false");
					default: put_str("true");
				endcase
			end
			jlkv_pkg::KIND_DIGITS: begin
				n = $urandom_range(0, 9) == 0 ? 20 : $urandom_range(0, 6);
				repeat (n) line_bytes.push_back(8'($urandom_range("0", "9")));
			end
			default: begin
				put_blanks();
				line_bytes.push_back(jlkv_pkg::CH_LBRACK);
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++) begin
					put_blanks();
					put_string(6);
					put_blanks();
					line_bytes.push_back(jlkv_pkg::CH_COMMA);
				end
				if ($urandom_range(0, 5) == 0)
					line_bytes.push_back("7");
				put_str("]");
			end
		endcase
	endtask

	// mostly well formed lines around the key, some broken, some noise
	task automatic build_line();
		int r;
		int k;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		put_str("{");
		if ($urandom_range(0, 2) == 0) put_str("\"id\": 12, ");
		if ($urandom_range(0, 2) == 0 && key_n > 0) begin
			line_bytes.push_back(jlkv_pkg::CH_QUOTE);
			k = $urandom_range(0, key_n - 1);
			for (int i = 0; i < k; i++) line_bytes.push_back(key_chars[i]);
			line_bytes.push_back($urandom_range(0, 3) == 0 ? jlkv_pkg::CH_QUOTE : "~");
			put_str("\":0,");
		end
		put_key();
		if (r == 1) begin
			repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			put_blanks();
			if (cur_kind == jlkv_pkg::KIND_ARRAY || $urandom_range(0, 12) != 0)
				line_bytes.push_back(jlkv_pkg::CH_COLON);
			put_blanks();
			put_value($urandom_range(0, 4) == 0 ? 2'($urandom_range(0, 3)) : cur_kind);
		end
		if ($urandom_range(0, 1)) put_str(", \"z\":\"x\"}");
		if ($urandom_range(0, 3) == 0) put_key();
	endtask

	// one setting: key, kind, index and capacity, then written to the block
	task automatic configure(input logic [1:0] k, input logic [8:0] cap,
			input logic [4:0] klen_reg);
		logic [63:0] lo;
		logic [63:0] hi;
		for (int i = 0; i < 16; i++) begin
			key_chars[i] = $urandom_range(0, 30) == 0 ? jlkv_pkg::CH_QUOTE :
				8'($urandom_range("a", "z"));
		end
		key_n = klen_reg > 16 ? 16 : klen_reg;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		for (int i = 0; i < 16; i++) begin
			if (i < key_n) begin
				if (i < 8) lo[8*i +: 8] = key_chars[i];
				else hi[8*(i-8) +: 8] = key_chars[i];
			end
		end
		cur_kind = k;
		write_reg(jlkv_pkg::REG_KEY_LEN, {$urandom, 27'($urandom), klen_reg});
		write_reg(jlkv_pkg::REG_KEY_LO, lo);
		write_reg(jlkv_pkg::REG_KEY_HI, hi);
		write_reg(jlkv_pkg::REG_KIND, {$urandom, 30'($urandom), k});
		write_reg(jlkv_pkg::REG_ELEM_IDX, {$urandom, 16'($urandom),
			$urandom_range(0, 9) == 0 ? 16'hffff : 16'($urandom_range(0, 3))});
		write_reg(jlkv_pkg::REG_CAPACITY, {$urandom, 23'($urandom), cap});
		settings_run++;
	endtask

	initial begin
		logic [8:0] cap;
		logic [4:0] klen;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty key with digits, then a boolean and a quoted string under a one-byte key
		configure(jlkv_pkg::KIND_DIGITS, 9'd256, 5'd0);
		put_str("\"\":42x");
		send_line();
		drain();
		configure(jlkv_pkg::KIND_BOOL, 9'd0, 5'd1);
		put_key();
		put_str(" :\tfalse");
		send_line();
		drain();
		configure(jlkv_pkg::KIND_STRING, 9'd3, 5'd1);
		put_key();
		put_str(":\"\\\"\"");
		send_line();
		drain();

		// random settings, extremes cycled in
		for (int ph = 0; bytes_sent < ITEM_TARGET; ph++) begin
			case (ph % 7)
				0: cap = 9'd256;
				1: cap = 9'd0;
				2: cap = 9'd1;
				3: cap = 9'd2;
				4: cap = 9'd511;
				default: cap = 9'($urandom_range(3, 12));
			endcase
			case (ph % 5)
				0: klen = 5'd16;
				1: klen = 5'd31;
				2: klen = 5'd0;
				default: klen = 5'($urandom_range(1, 6));
			endcase
			configure(2'(ph % 4), cap, klen);
			repeat (8) begin
				build_line();
				send_line();
			end
			drain();
		end

		$display("%0d text bytes in %0d lines over %0d register settings", bytes_sent,
			lines_sent, settings_run);
		$display("%0d successful statuses, %0d mismatches", statuses_ok, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
